// ===== src/icc_pkg.sv =====
// Package: shared constants and codes for the center-border image convolution block.
package icc_pkg;

  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxKernelDef = 15;
  localparam int unsigned MaxHeight    = 4096;

  localparam int unsigned PixW   = 16;
  localparam int unsigned CoefW  = 18;
  localparam int unsigned ProdW  = PixW + CoefW;
  localparam int unsigned AccW   = ProdW + 8;
  localparam int unsigned RowW   = 13;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_PIXEL = 2'd1,
    OP_DRAIN = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_IMG_W = 2'd0,
    CFG_IMG_H = 2'd1,
    CFG_KER_W = 2'd2,
    CFG_KER_H = 2'd3
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ADDR,
    ST_READ,
    ST_MAC,
    ST_ROUND,
    ST_OUT
  } state_e;

endpackage

// ===== src/icc_mac.sv =====
// Shared multiply-accumulate unit with round-to-Q12.4 and saturation.
module icc_mac
  import icc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clr_i,
  input  logic                    en_i,
  input  logic signed [PixW-1:0]  pix_i,
  input  logic signed [CoefW-1:0] coef_i,
  output logic signed [PixW-1:0]  result_o
);

  logic signed [ProdW-1:0] prod_q;
  logic                    prod_vld_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [AccW-1:0]  rnd;
  logic signed [AccW-17:0] shr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= en_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(pix_i) * ProdW'(coef_i);
    if (clr_i) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
  end

  // add half an LSB, then floor via arithmetic shift
  always_comb begin
    rnd = acc_q + AccW'(32768);
    shr = rnd[AccW-1:16];
    if (shr > (AccW-16)'(32767)) begin
      result_o = 16'sh7fff;
    end else if (shr < -(AccW-16)'(32768)) begin
      result_o = -16'sh8000;
    end else begin
      result_o = shr[PixW-1:0];
    end
  end

endmodule

// ===== src/image_convolution_center_border.sv =====
// Top level: streaming 2D correlation with center-pixel border handling.
// A coefficient load or an ignored opcode is taken in ST_IDLE; a pixel or drain request with
// no result returns from ST_CHECK to ST_IDLE. A filtered pixel passes through the single
// shared MAC and the registered store reads, each kernel tap in ST_ADDR, ST_READ and ST_MAC,
// then ST_ROUND and ST_OUT; no new request is taken until ST_IDLE. A finished pixel waits in
// the output register and the next one stalls only while that register is still full.
// Reset (async, active low) sets registers to 1024x1024, 3x3 and clears the counters;
// kernel and line stores are not cleared.
module image_convolution_center_border
  import icc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_KERNEL = MaxKernelDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic [7:0]         coef_index_i,
  input  logic signed [17:0] coef_value_i,
  input  logic signed [15:0] pixel_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] pixel_out_o,
  output logic               frame_last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [12:0]        cfg_data_i
);

  localparam int unsigned KDepth = MAX_KERNEL * MAX_KERNEL;
  localparam int unsigned KAw    = $clog2(KDepth);
  localparam int unsigned LDepth = MAX_WIDTH * MAX_KERNEL;
  localparam int unsigned LAw    = $clog2(LDepth);
  localparam int unsigned WW     = $clog2(MAX_WIDTH + 1);
  localparam int unsigned KW     = $clog2(MAX_KERNEL + 1);
  localparam int unsigned CntW   = $clog2(MAX_WIDTH * MaxHeight);
  localparam logic signed [LAw+1:0] LDepthS = (LAw+2)'(LDepth);

  logic [10:0] img_w_q;
  logic [12:0] img_h_q;
  logic [3:0]  ker_w_q, ker_h_q;
  logic [CntW-1:0] in_cnt_q, in_cnt_d, out_cnt_q, out_cnt_d;
  logic [LAw-1:0]  in_ptr_q, in_ptr_d, out_ptr_q, out_ptr_d;
  state_e state_q, state_d;

  logic signed [CoefW-1:0] kmem [KDepth];
  logic signed [PixW-1:0]  lmem [LDepth];

  // effective (clamped) configuration
  logic [WW-1:0]  wid;
  logic [RowW:0]  hgt;
  logic [KW-1:0]  kw, kh, hw, hh;
  logic [CntW:0]   total;
  logic [CntW-1:0] lag, last_pos;

  always_comb begin
    if (img_w_q == '0) wid = WW'(1);
    else if (32'(img_w_q) > MAX_WIDTH) wid = WW'(MAX_WIDTH);
    else wid = WW'(img_w_q);
    if (img_h_q == '0) hgt = (RowW+1)'(1);
    else if (32'(img_h_q) > MaxHeight) hgt = (RowW+1)'(MaxHeight);
    else hgt = (RowW+1)'(img_h_q);
    if (ker_w_q == '0) kw = KW'(1);
    else if (32'(ker_w_q) > MAX_KERNEL) kw = KW'(MAX_KERNEL);
    else kw = KW'(ker_w_q);
    if (ker_h_q == '0) kh = KW'(1);
    else if (32'(ker_h_q) > MAX_KERNEL) kh = KW'(MAX_KERNEL);
    else kh = KW'(ker_h_q);
    hw = (kw - KW'(1)) >> 1;
    hh = (kh - KW'(1)) >> 1;
  end

  // frame size and output lag follow the registers directly
  assign total    = (CntW+1)'(32'(wid) * 32'(hgt));
  assign lag      = CntW'(32'(hh) * 32'(wid) + 32'(hw));
  assign last_pos = CntW'(total - (CntW+1)'(1));

  // position of the current output pixel, kept as row/col alongside out_cnt
  logic [RowW-1:0] row_q, row_d;
  logic [WW-1:0]   col_q, col_d;
  logic [KW-1:0]   th_q, th_d, tk_q, tk_d;
  logic [KAw-1:0]  kidx_q, kidx_d;
  logic signed [RowW+1:0] tr;
  logic signed [WW+1:0]   tc;
  logic            in_img;
  logic signed [KW:0]    dr, dc;
  logic signed [LAw+1:0] toff, tsum;
  logic [LAw-1:0]  taddr_q, taddr_d;
  logic [LAw-1:0]  center_a;
  logic [LAw-1:0]  tap_a;
  logic            use_ctr_q, use_ctr_d;
  logic signed [PixW-1:0]  lrd_q, ctr_q;
  logic signed [CoefW-1:0] krd_q;
  logic            mac_clr, mac_en;
  logic signed [PixW-1:0] mac_res;
  logic signed [PixW-1:0] res_q;
  logic            last_q, last_d, ovld_q, ovld_d;
  logic            ctr_ld;
  logic [1:0]      wait_q, wait_d;

  assign tr = $signed({2'b0, row_q}) - $signed({2'b0, (RowW)'(hh)})
            + $signed({2'b0, (RowW)'(th_q)});
  assign tc = $signed({2'b0, col_q}) - $signed({2'b0, WW'(hw)})
            + $signed({2'b0, WW'(tk_q)});
  assign in_img = (tr >= 0) && (tc >= 0) && (tr < $signed({1'b0, hgt}))
               && (tc < $signed({2'b0, wid}));

  // tap address relative to the center pixel, folded back into the ring
  assign dr   = $signed({1'b0, th_q}) - $signed({1'b0, hh});
  assign dc   = $signed({1'b0, tk_q}) - $signed({1'b0, hw});
  assign toff = (LAw+2)'(dr) * (LAw+2)'($signed({1'b0, wid})) + (LAw+2)'(dc);
  assign tsum = $signed({2'b0, out_ptr_q}) + toff;

  assign center_a = out_ptr_q;
  assign tap_a    = taddr_q;

  icc_mac u_mac (
    .clk_i, .rst_ni,
    .clr_i   (mac_clr),
    .en_i    (mac_en),
    .pix_i   (use_ctr_q ? ctr_q : lrd_q),
    .coef_i  (krd_q),
    .result_o(mac_res)
  );

  wire in_acc  = in_valid_i && !in_stall_o;
  wire cfg_acc = cfg_valid_i && cfg_ready_o;
  wire pix_wr  = in_acc && (op_e'(opcode_i) == OP_PIXEL) && ({1'b0, in_cnt_q} < total);

  // a pending register write goes ahead of the next request
  assign in_stall_o   = (state_q != ST_IDLE) || cfg_valid_i;
  assign cfg_ready_o  = (state_q == ST_IDLE) && !ovld_q;
  assign out_valid_o  = ovld_q;
  assign pixel_out_o  = res_q;
  assign frame_last_o = last_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && (op_e'(opcode_i) == OP_LOAD) && (32'(coef_index_i) < KDepth)) begin
      kmem[KAw'(coef_index_i)] <= coef_value_i;
    end
    krd_q <= kmem[kidx_q];
  end

  always_ff @(posedge clk_i) begin
    if (pix_wr) begin
      lmem[in_ptr_q] <= pixel_in_i;
    end
    lrd_q <= lmem[ctr_ld ? center_a : tap_a];
    if (ctr_ld) ctr_q <= lrd_q;
    if (state_q == ST_OUT && !ovld_q) res_q <= mac_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q   <= 11'd1024;
      img_h_q   <= 13'd1024;
      ker_w_q   <= 4'd3;
      ker_h_q   <= 4'd3;
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      in_ptr_q  <= '0;
      out_ptr_q <= '0;
      state_q   <= ST_IDLE;
      row_q     <= '0;
      col_q     <= '0;
      th_q      <= '0;
      tk_q      <= '0;
      kidx_q    <= '0;
      taddr_q   <= '0;
      use_ctr_q <= 1'b0;
      last_q    <= 1'b0;
      ovld_q    <= 1'b0;
      wait_q    <= '0;
    end else begin
      in_cnt_q  <= in_cnt_d;
      out_cnt_q <= out_cnt_d;
      in_ptr_q  <= in_ptr_d;
      out_ptr_q <= out_ptr_d;
      state_q   <= state_d;
      row_q     <= row_d;
      col_q     <= col_d;
      th_q      <= th_d;
      tk_q      <= tk_d;
      kidx_q    <= kidx_d;
      taddr_q   <= taddr_d;
      use_ctr_q <= use_ctr_d;
      last_q    <= last_d;
      ovld_q    <= ovld_d;
      wait_q    <= wait_d;
      if (cfg_acc) begin
        case (cfg_e'(cfg_index_i))
          CFG_IMG_W: img_w_q <= cfg_data_i[10:0];
          CFG_IMG_H: img_h_q <= cfg_data_i;
          CFG_KER_W: ker_w_q <= cfg_data_i[3:0];
          CFG_KER_H: ker_h_q <= cfg_data_i[3:0];
          default:   ;
        endcase
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    in_cnt_d  = in_cnt_q;
    out_cnt_d = out_cnt_q;
    in_ptr_d  = in_ptr_q;
    out_ptr_d = out_ptr_q;
    row_d     = row_q;
    col_d     = col_q;
    th_d      = th_q;
    tk_d      = tk_q;
    kidx_d    = kidx_q;
    taddr_d   = taddr_q;
    use_ctr_d = use_ctr_q;
    last_d    = last_q;
    ovld_d    = ovld_q && out_stall_i;
    wait_d    = wait_q;
    mac_clr   = 1'b0;
    mac_en    = 1'b0;
    ctr_ld    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cfg_acc) begin
          in_cnt_d  = '0;
          out_cnt_d = '0;
          in_ptr_d  = '0;
          out_ptr_d = '0;
          row_d     = '0;
          col_d     = '0;
        end else if (in_acc) begin
          if (pix_wr) begin
            in_cnt_d = in_cnt_q + CntW'(1);
            in_ptr_d = (in_ptr_q == LAw'(LDepth - 1)) ? '0 : in_ptr_q + LAw'(1);
          end
          if (op_e'(opcode_i) == OP_PIXEL || op_e'(opcode_i) == OP_DRAIN) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (({1'b0, out_cnt_q} < total) &&
            (({1'b0, in_cnt_q} == total) ||
             ({1'b0, in_cnt_q} > {1'b0, out_cnt_q} + {1'b0, lag}))) begin
          ctr_ld  = 1'b1;
          mac_clr = 1'b1;
          th_d    = '0;
          tk_d    = '0;
          wait_d  = 2'd1;
          state_d = ST_ADDR;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ADDR: begin
        // center pixel arrives in lrd_q in the cycle after ctr_ld
        if (wait_q != '0) begin
          ctr_ld = 1'b1;
          wait_d = '0;
        end
        use_ctr_d = !in_img;
        if (tsum < 0) taddr_d = LAw'(tsum + LDepthS);
        else if (tsum >= LDepthS) taddr_d = LAw'(tsum - LDepthS);
        else taddr_d = LAw'(tsum);
        kidx_d    = KAw'(32'(th_q) * 32'(kw) + 32'(tk_q));
        state_d   = ST_READ;
      end
      ST_READ: begin
        state_d = ST_MAC;
      end
      ST_MAC: begin
        mac_en = 1'b1;
        if (tk_q == kw - KW'(1)) begin
          tk_d = '0;
          if (th_q == kh - KW'(1)) state_d = ST_ROUND;
          else begin
            th_d    = th_q + KW'(1);
            state_d = ST_ADDR;
          end
        end else begin
          tk_d    = tk_q + KW'(1);
          state_d = ST_ADDR;
        end
        if (state_d == ST_ROUND) wait_d = 2'd2;
      end
      ST_ROUND: begin
        // let the last product land in the accumulator
        if (wait_q != '0) begin
          wait_d = wait_q - 2'd1;
          if (wait_q == 2'd1) state_d = ST_OUT;
          else state_d = ST_ROUND;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ovld_q) begin
          ovld_d = 1'b1;
          last_d = (out_cnt_q == last_pos);
          if (out_cnt_q == last_pos) begin
            out_cnt_d = '0;
            in_cnt_d  = '0;
            out_ptr_d = '0;
            in_ptr_d  = '0;
            row_d     = '0;
            col_d     = '0;
          end else begin
            out_cnt_d = out_cnt_q + CntW'(1);
            out_ptr_d = (out_ptr_q == LAw'(LDepth - 1)) ? '0 : out_ptr_q + LAw'(1);
            if (col_q == wid - WW'(1)) begin
              col_d = '0;
              row_d = row_q + RowW'(1);
            end else begin
              col_d = col_q + WW'(1);
            end
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
